[src/pbl_pkg.sv]
// Shared constants and types for the partition box lookup block.
package pbl_pkg;

	// Fixed field widths of the item ports
	localparam int SLOT_BITS     = 10;
	localparam int STATUS_BITS   = 2;
	// Wide enough to hold any slot number or table depth up to 65536
	localparam int SLOT_EXT_BITS = 17;

	// Item kinds
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Query answers
	typedef logic [STATUS_BITS-1:0] status_t;
	localparam status_t STATUS_CONTAINED = 2'd0;
	localparam status_t STATUS_BOUNDARY  = 2'd1;
	localparam status_t STATUS_OUTSIDE   = 2'd2;

	// Verdict of one rectangle-versus-box comparison
	typedef struct packed {
		logic contains;
		logic intersects;
	} cmp_res_t;

	// Table write port
	typedef struct packed {
		logic en;
		logic valid_mark;
	} tbl_wr_ctl_t;

endpackage

[src/pbl_slot_table.sv]
// Rectangle table with one write port and a registered read port.
module pbl_slot_table #(
	parameter int DEPTH     = 1024,
	parameter int ADDR_BITS = 10,
	parameter int DATA_BITS = 128
) (
	input  logic                        clk,
	input  pbl_pkg::tbl_wr_ctl_t        wr_ctl,
	input  logic [ADDR_BITS-1:0]        wr_addr,
	input  logic [DATA_BITS-1:0]        wr_data,
	input  logic                        rd_en,
	input  logic [ADDR_BITS-1:0]        rd_addr,
	output logic                        rd_valid_mark,
	output logic [DATA_BITS-1:0]        rd_data
);
	import pbl_pkg::*;

	// Each entry carries its valid mark in the top bit
	logic [DATA_BITS:0] mem [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (wr_ctl.en) begin
			mem[wr_addr] <= {wr_ctl.valid_mark, wr_data};
		end
		if (rd_en) begin
			{rd_valid_mark, rd_data} <= mem[rd_addr];
		end
	end

endmodule

[src/pbl_box_cmp.sv]
// Shared compare unit: containment and closed-edge overlap of two rectangles.
module pbl_box_cmp #(
	parameter int COORD_BITS = 32
) (
	input  logic signed [COORD_BITS-1:0] ent_x_lo,
	input  logic signed [COORD_BITS-1:0] ent_y_lo,
	input  logic signed [COORD_BITS-1:0] ent_x_hi,
	input  logic signed [COORD_BITS-1:0] ent_y_hi,
	input  logic signed [COORD_BITS-1:0] box_x_lo,
	input  logic signed [COORD_BITS-1:0] box_y_lo,
	input  logic signed [COORD_BITS-1:0] box_x_hi,
	input  logic signed [COORD_BITS-1:0] box_y_hi,
	output pbl_pkg::cmp_res_t            res
);
	import pbl_pkg::*;

	// Box lies fully inside the entry, edges included
	assign res.contains = (box_x_lo >= ent_x_lo) && (box_x_hi <= ent_x_hi) &&
		(box_y_lo >= ent_y_lo) && (box_y_hi <= ent_y_hi);

	// Box and entry share at least one point
	assign res.intersects = !((box_x_lo > ent_x_hi) || (box_x_hi < ent_x_lo) ||
		(box_y_lo > ent_y_hi) || (box_y_hi < ent_y_lo));

endmodule

[src/partition_box_lookup_core.sv]
// Partition box lookup: rectangle table with a sequential first-match scan.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  in      | in_valid, in_ready, mode, slot, x/y_low, x/y_high | into block
//  out     | out_valid, out_ready, status, partition          | from block
//
// A load gives no result. A query scans the table one slot per cycle
// through the single table read port and the shared compare unit, and the
// scan ends early when a containing slot is hit.
// After reset a clearing pass walks all NUM_SLOTS entries, one per cycle,
// before the first transfer is taken. The block holds in_ready low while a
// query runs and while its result waits for out_ready.
module partition_box_lookup_core #(
	parameter int NUM_SLOTS  = 1024,
	parameter int COORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              mode,
	input  logic [pbl_pkg::SLOT_BITS-1:0]     slot,
	input  logic signed [COORD_BITS-1:0]      x_low,
	input  logic signed [COORD_BITS-1:0]      y_low,
	input  logic signed [COORD_BITS-1:0]      x_high,
	input  logic signed [COORD_BITS-1:0]      y_high,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [pbl_pkg::STATUS_BITS-1:0]   status,
	output logic [pbl_pkg::SLOT_BITS-1:0]     partition
);
	import pbl_pkg::*;

	localparam int ADDR_BITS = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int RECT_BITS = 4 * COORD_BITS;
	localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(NUM_SLOTS - 1);
	localparam logic [SLOT_EXT_BITS-1:0] DEPTH_EXT = SLOT_EXT_BITS'(NUM_SLOTS);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [ADDR_BITS-1:0]    addr_q;
	logic                    issue_q;
	logic                    rd_vld_s1;
	logic [ADDR_BITS-1:0]    idx_s1;
	status_t                 status_q;
	logic [SLOT_BITS-1:0]    part_q;

	logic signed [COORD_BITS-1:0] box_x_lo_q, box_y_lo_q, box_x_hi_q, box_y_hi_q;
	logic signed [COORD_BITS-1:0] n_x_lo, n_y_lo, n_x_hi, n_y_hi;

	logic [SLOT_EXT_BITS-1:0] slot_ext;
	logic [SLOT_EXT_BITS-1:0] idx_ext;
	logic                     slot_in_range;
	logic                     in_xfer;
	logic                     load_xfer;
	logic                     query_xfer;

	tbl_wr_ctl_t              wr_ctl;
	logic [ADDR_BITS-1:0]     wr_addr;
	logic [RECT_BITS-1:0]     wr_data;
	logic                     rd_en;
	logic                     ent_valid;
	logic [RECT_BITS-1:0]     ent_data;
	cmp_res_t                 cmp_res;
	logic                     hit_valid;

	// Normalize swapped corners
	assign n_x_lo = (x_low <= x_high) ? x_low  : x_high;
	assign n_x_hi = (x_low <= x_high) ? x_high : x_low;
	assign n_y_lo = (y_low <= y_high) ? y_low  : y_high;
	assign n_y_hi = (y_low <= y_high) ? y_high : y_low;

	// Decode the input transfer
	assign slot_ext      = SLOT_EXT_BITS'(slot);
	assign slot_in_range = slot_ext < DEPTH_EXT;
	assign in_ready      = (state_q == ST_IDLE);
	assign in_xfer       = in_valid && in_ready;
	assign load_xfer     = in_xfer && (mode == MODE_LOAD);
	assign query_xfer    = in_xfer && (mode == MODE_QUERY);

	// Table write: clearing pass or a load
	always_comb begin
		wr_ctl.en         = (state_q == ST_CLEAR) || (load_xfer && slot_in_range);
		wr_ctl.valid_mark = (state_q != ST_CLEAR);
		wr_addr           = (state_q == ST_CLEAR) ? addr_q : slot_ext[ADDR_BITS-1:0];
		wr_data           = (state_q == ST_CLEAR) ? '0 : {n_x_lo, n_y_lo, n_x_hi, n_y_hi};
	end

	assign rd_en = (state_q == ST_SCAN) && issue_q;

	pbl_slot_table #(
		.DEPTH     (NUM_SLOTS),
		.ADDR_BITS (ADDR_BITS),
		.DATA_BITS (RECT_BITS)
	) u_table (
		.clk           (clk),
		.wr_ctl        (wr_ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr       (addr_q),
		.rd_valid_mark (ent_valid),
		.rd_data       (ent_data)
	);

	pbl_box_cmp #(
		.COORD_BITS (COORD_BITS)
	) u_cmp (
		.ent_x_lo (ent_data[4*COORD_BITS-1:3*COORD_BITS]),
		.ent_y_lo (ent_data[3*COORD_BITS-1:2*COORD_BITS]),
		.ent_x_hi (ent_data[2*COORD_BITS-1:COORD_BITS]),
		.ent_y_hi (ent_data[COORD_BITS-1:0]),
		.box_x_lo (box_x_lo_q),
		.box_y_lo (box_y_lo_q),
		.box_x_hi (box_x_hi_q),
		.box_y_hi (box_y_hi_q),
		.res      (cmp_res)
	);

	assign hit_valid = rd_vld_s1 && ent_valid;
	assign idx_ext   = SLOT_EXT_BITS'(idx_s1);

	// Hold the query box for the whole scan
	always_ff @(posedge clk) begin
		if (query_xfer) begin
			box_x_lo_q <= n_x_lo;
			box_y_lo_q <= n_y_lo;
			box_x_hi_q <= n_x_hi;
			box_y_hi_q <= n_y_hi;
		end
	end

	// Sequencer: clear, accept, scan, present the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
			idx_s1    <= '0;
			status_q  <= STATUS_OUTSIDE;
			part_q    <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			idx_s1    <= addr_q;
			unique case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (query_xfer) begin
						addr_q    <= '0;
						issue_q   <= 1'b1;
						status_q  <= STATUS_OUTSIDE;
						part_q    <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// advance the read address while slots are still issued
					if (issue_q) begin
						addr_q <= addr_q + 1'b1;
					end
					// first containing slot ends the scan
					if (hit_valid && cmp_res.contains) begin
						status_q <= STATUS_CONTAINED;
						part_q   <= idx_ext[SLOT_BITS-1:0];
						issue_q  <= 1'b0;
						state_q  <= ST_DONE;
					end else begin
						if (hit_valid && cmp_res.intersects) begin
							status_q <= STATUS_BOUNDARY;
						end
						if (rd_vld_s1 && (idx_s1 == LAST_ADDR)) begin
							issue_q <= 1'b0;
							state_q <= ST_DONE;
						end else if (issue_q && (addr_q == LAST_ADDR)) begin
							// last slot issued, stop reading
							issue_q <= 1'b0;
						end
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = (state_q == ST_DONE);
	assign status    = status_q;
	assign partition = part_q;

endmodule

[test/pbl_lookup_checker.sv]
// Channel monitor, table predictor and answer comparator for the partition box lookup core.
module pbl_lookup_checker #(
	parameter int NUM_SLOTS  = 1024,
	parameter int COORD_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              mode,
	input  logic [pbl_pkg::SLOT_BITS-1:0]     slot,
	input  logic signed [COORD_BITS-1:0]      x_low,
	input  logic signed [COORD_BITS-1:0]      y_low,
	input  logic signed [COORD_BITS-1:0]      x_high,
	input  logic signed [COORD_BITS-1:0]      y_high,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [pbl_pkg::STATUS_BITS-1:0]   status,
	input  logic [pbl_pkg::SLOT_BITS-1:0]     partition,
	output int                                errors,
	output int                                pending,
	output int                                n_contained,
	output int                                n_boundary,
	output int                                n_outside
);
	import pbl_pkg::*;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		status_t               status;
		logic [SLOT_BITS-1:0]  partition;
	} lookup_answer_t;

	// Shadow copy of the partition table, normalized on write
	coord_t tbl_x_lo [NUM_SLOTS];
	coord_t tbl_y_lo [NUM_SLOTS];
	coord_t tbl_x_hi [NUM_SLOTS];
	coord_t tbl_y_hi [NUM_SLOTS];
	bit     tbl_used [NUM_SLOTS];

	lookup_answer_t answer_q[$];
	int err_cnt;
	int cnt_contained;
	int cnt_boundary;
	int cnt_outside;

	// Scan the valid slots in ascending order for the first one holding the box
	function automatic lookup_answer_t predict_lookup(coord_t bx_lo, coord_t by_lo,
			coord_t bx_hi, coord_t by_hi);
		lookup_answer_t ans;
		bit found;
		ans.status    = STATUS_OUTSIDE;
		ans.partition = '0;
		found = 1'b0;
		for (int i = 0; i < NUM_SLOTS && !found; i++) begin
			if (tbl_used[i] &&
					!(bx_lo > tbl_x_hi[i] || bx_hi < tbl_x_lo[i] ||
					  by_lo > tbl_y_hi[i] || by_hi < tbl_y_lo[i])) begin
				if (bx_lo >= tbl_x_lo[i] && bx_hi <= tbl_x_hi[i] &&
						by_lo >= tbl_y_lo[i] && by_hi <= tbl_y_hi[i]) begin
					ans.status    = STATUS_CONTAINED;
					ans.partition = SLOT_BITS'(i);
					found         = 1'b1;
				end else begin
					ans.status = STATUS_BOUNDARY;
				end
			end
		end
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		coord_t         nx_lo, nx_hi, ny_lo, ny_hi;
		lookup_answer_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				tbl_used[i] = 1'b0;
			end
			answer_q.delete();
			err_cnt       = 0;
			cnt_contained = 0;
			cnt_boundary  = 0;
			cnt_outside   = 0;
			errors      <= 0;
			pending     <= 0;
			n_contained <= 0;
			n_boundary  <= 0;
			n_outside   <= 0;
		end else begin
			// Retire a result transfer against the oldest open query
			if (out_valid && out_ready) begin
				if (answer_q.size() == 0) begin
					err_cnt++;
					$display("%0t: result with no query open: expected none, got status %0d partition %0d",
						$time, status, partition);
				end else begin
					want = answer_q.pop_front();
					if (status !== want.status) begin
						err_cnt++;
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, status);
					end
					if (partition !== want.partition) begin
						err_cnt++;
						$display("%0t: partition mismatch: expected %0d, got %0d",
							$time, want.partition, partition);
					end
					case (want.status)
						STATUS_CONTAINED: cnt_contained++;
						STATUS_BOUNDARY:  cnt_boundary++;
						default:          cnt_outside++;
					endcase
				end
			end

			// Normalize the transferred rectangle, then store it or predict the answer
			if (in_valid && in_ready) begin
				nx_lo = (x_low < x_high) ? x_low : x_high;
				nx_hi = (x_low < x_high) ? x_high : x_low;
				ny_lo = (y_low < y_high) ? y_low : y_high;
				ny_hi = (y_low < y_high) ? y_high : y_low;
				if (mode == MODE_LOAD) begin
					if (int'(slot) < NUM_SLOTS) begin
						tbl_x_lo[slot] = nx_lo;
						tbl_y_lo[slot] = ny_lo;
						tbl_x_hi[slot] = nx_hi;
						tbl_y_hi[slot] = ny_hi;
						tbl_used[slot] = 1'b1;
					end
				end else begin
					answer_q.push_back(predict_lookup(nx_lo, ny_lo, nx_hi, ny_hi));
				end
			end

			errors      <= err_cnt;
			pending     <= answer_q.size();
			n_contained <= cnt_contained;
			n_boundary  <= cnt_boundary;
			n_outside   <= cnt_outside;
		end
	end

endmodule

[test/tb_partition_box_lookup_core.sv]
// Stimulus, pacing and verdict for the partition box lookup core.
module tb_partition_box_lookup_core;
	import pbl_pkg::*;

	localparam int     NUM_SLOTS    = 1024;
	localparam int     COORD_BITS   = 32;
	localparam int     RANDOM_ITEMS = 560;
	localparam int     CYCLE_LIMIT  = 3_000_000;
	localparam longint COORD_MIN    = -64'sd2147483648;
	localparam longint COORD_MAX    = 64'sd2147483647;
	localparam longint REGION       = 64'sd1048576;
	localparam longint SPREAD       = 64'sd262144;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	logic                          mode      = MODE_LOAD;
	logic [SLOT_BITS-1:0]          slot      = '0;
	logic signed [COORD_BITS-1:0]  x_low     = '0;
	logic signed [COORD_BITS-1:0]  y_low     = '0;
	logic signed [COORD_BITS-1:0]  x_high    = '0;
	logic signed [COORD_BITS-1:0]  y_high    = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [STATUS_BITS-1:0]        status;
	logic [SLOT_BITS-1:0]          partition;

	int chk_errors;
	int chk_pending;
	int chk_contained;
	int chk_boundary;
	int chk_outside;

	// Pacing knobs, in percent of cycles spent idle
	int snd_idle_pct = 10;
	int rcv_idle_pct = 73;

	// What has been loaded so far, used only to aim queries at real rectangles
	longint sh_x_lo [NUM_SLOTS];
	longint sh_y_lo [NUM_SLOTS];
	longint sh_x_hi [NUM_SLOTS];
	longint sh_y_hi [NUM_SLOTS];
	bit     sh_used [NUM_SLOTS];
	int     loaded_slots[$];

	int n_loads   = 0;
	int n_queries = 0;
	int cycle_cnt = 0;

	partition_box_lookup_core #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COORD_BITS (COORD_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.slot      (slot),
		.x_low     (x_low),
		.y_low     (y_low),
		.x_high    (x_high),
		.y_high    (y_high),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.partition (partition)
	);

	pbl_lookup_checker #(
		.NUM_SLOTS  (NUM_SLOTS),
		.COORD_BITS (COORD_BITS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.slot        (slot),
		.x_low       (x_low),
		.y_low       (y_low),
		.x_high      (x_high),
		.y_high      (y_high),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.partition   (partition),
		.errors      (chk_errors),
		.pending     (chk_pending),
		.n_contained (chk_contained),
		.n_boundary  (chk_boundary),
		.n_outside   (chk_outside)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Stall the result channel at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// Abort a hung run
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles", cycle_cnt);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint rand_coord();
		return longint'(int'($urandom));
	endfunction

	function automatic longint clamp_coord(longint v);
		return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
	endfunction

	// Uniform pick in the closed range lo..hi
	function automatic longint pick_between(longint lo, longint hi);
		longint unsigned span;
		longint unsigned r;
		if (hi <= lo) begin
			return lo;
		end
		span = longint'(hi - lo) + 1;
		r    = {$urandom, $urandom};
		return lo + longint'(r % span);
	endfunction

	// Present one item after a random gap and hold it until the transfer
	task automatic send_item(input logic m, input int unsigned s, input longint xl,
			input longint yl, input longint xh, input longint yh);
		int gap;
		gap = 0;
		while (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		slot     <= s[SLOT_BITS-1:0];
		x_low    <= xl[COORD_BITS-1:0];
		y_low    <= yl[COORD_BITS-1:0];
		x_high   <= xh[COORD_BITS-1:0];
		y_high   <= yh[COORD_BITS-1:0];
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (m == MODE_LOAD) begin
			n_loads++;
			if (s < NUM_SLOTS) begin
				sh_x_lo[s] = (xl < xh) ? xl : xh;
				sh_x_hi[s] = (xl < xh) ? xh : xl;
				sh_y_lo[s] = (yl < yh) ? yl : yh;
				sh_y_hi[s] = (yl < yh) ? yh : yl;
				if (!sh_used[s]) begin
					loaded_slots.push_back(s);
				end
				sh_used[s] = 1'b1;
			end
		end else begin
			n_queries++;
		end
	endtask

	// Hold the sender until every open query has answered
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin : stimulus
		int          kind;
		int          sel;
		int unsigned s;
		int          ps;
		longint      xl, yl, xh, yh, cx, cy, wx, wy, tmp;

		for (int i = 0; i < NUM_SLOTS; i++) begin
			sh_used[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty table, full plane, closed edges, reload, swapped corners, extremes
		send_item(MODE_QUERY, 0, 0, 0, 0, 0);
		send_item(MODE_LOAD, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
		send_item(MODE_QUERY, 1023, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
		send_item(MODE_LOAD, 0, 100, 100, 200, 200);
		send_item(MODE_QUERY, 0, 100, 100, 200, 200);
		send_item(MODE_QUERY, 0, 150, 150, 250, 250);
		send_item(MODE_QUERY, 0, 200, 200, 300, 300);
		send_item(MODE_QUERY, 0, 201, 100, 300, 200);
		send_item(MODE_LOAD, 1023, 1000, 1000, -1000, -1000);
		send_item(MODE_QUERY, 0, 160, 150, 150, 160);
		send_item(MODE_QUERY, 512, 10, -10, -10, 10);
		send_item(MODE_QUERY, 0, -1000, -1000, 1000, 1001);
		send_item(MODE_LOAD, 512, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_item(MODE_QUERY, 0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_item(MODE_LOAD, 1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_item(MODE_QUERY, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_item(MODE_QUERY, 0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
		send_item(MODE_LOAD, 682, -64'sd1431655766, -64'sd1431655766,
			64'sd1431655765, 64'sd1431655765);
		send_item(MODE_QUERY, 341, 0, 0, 0, 0);
		send_item(MODE_LOAD, 341, 64'sd1431655765, 64'sd1431655765,
			-64'sd1431655766, -64'sd1431655766);
		wait_drained();

		// Random part in three pacing phases
		snd_idle_pct = 10;
		rcv_idle_pct <= 73;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				wait_drained();
				snd_idle_pct = 73;
				rcv_idle_pct <= 10;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				wait_drained();
				snd_idle_pct = 0;
				rcv_idle_pct <= 0;
			end

			kind = $urandom_range(99);
			sel  = $urandom_range(99);
			if (kind < 45) begin
				// Load: mostly a few crowded slots, sometimes any slot
				case ($urandom_range(9))
					0, 1, 2, 3, 4: s = $urandom_range(15);
					5, 6:          s = 1008 + $urandom_range(15);
					default:       s = $urandom_range(NUM_SLOTS - 1);
				endcase
				if (sel < 70) begin
					cx = pick_between(-REGION, REGION);
					cy = pick_between(-REGION, REGION);
					wx = pick_between(0, SPREAD);
					wy = pick_between(0, SPREAD);
					xl = cx - wx;
					xh = cx + wx;
					yl = cy - wy;
					yh = cy + wy;
				end else if (sel < 95) begin
					xl = rand_coord();
					yl = rand_coord();
					xh = rand_coord();
					yh = rand_coord();
				end else begin
					xl = $urandom_range(1) ? COORD_MIN : COORD_MAX;
					yl = $urandom_range(1) ? COORD_MIN : COORD_MAX;
					xh = $urandom_range(1) ? COORD_MIN : COORD_MAX;
					yh = $urandom_range(1) ? COORD_MIN : COORD_MAX;
				end
			end else begin
				// Query: aim at a loaded rectangle, its edges, or open space
				s = $urandom_range(NUM_SLOTS - 1);
				if (loaded_slots.size() == 0) begin
					sel = 99;
				end
				ps = (loaded_slots.size() == 0) ? 0 :
					loaded_slots[$urandom_range(loaded_slots.size() - 1)];
				if (sel < 40) begin
					xl = pick_between(sh_x_lo[ps], sh_x_hi[ps]);
					xh = pick_between(xl, sh_x_hi[ps]);
					yl = pick_between(sh_y_lo[ps], sh_y_hi[ps]);
					yh = pick_between(yl, sh_y_hi[ps]);
				end else if (sel < 60) begin
					xl = pick_between(clamp_coord(sh_x_lo[ps] - SPREAD), sh_x_lo[ps]);
					xh = pick_between(sh_x_lo[ps], sh_x_hi[ps]);
					yl = pick_between(sh_y_lo[ps], sh_y_hi[ps]);
					yh = pick_between(yl, clamp_coord(sh_y_hi[ps] + SPREAD));
				end else if (sel < 65) begin
					if ($urandom_range(1)) begin
						xh = sh_x_lo[ps];
						xl = pick_between(clamp_coord(xh - SPREAD), xh);
					end else begin
						xl = sh_x_hi[ps];
						xh = pick_between(xl, clamp_coord(xl + SPREAD));
					end
					yl = pick_between(sh_y_lo[ps], sh_y_hi[ps]);
					yh = pick_between(yl, sh_y_hi[ps]);
				end else if (sel < 85) begin
					xl = pick_between(-2 * REGION, 2 * REGION);
					yl = pick_between(-2 * REGION, 2 * REGION);
					xh = xl + pick_between(0, SPREAD);
					yh = yl + pick_between(0, SPREAD);
				end else begin
					xl = rand_coord();
					yl = rand_coord();
					xh = rand_coord();
					yh = rand_coord();
				end
			end

			// Swap corners now and then; the block must normalize them
			if ($urandom_range(3) == 0) begin
				tmp = xl;
				xl  = xh;
				xh  = tmp;
			end
			if ($urandom_range(3) == 0) begin
				tmp = yl;
				yl  = yh;
				yh  = tmp;
			end
			send_item((kind < 45) ? MODE_LOAD : MODE_QUERY, s, xl, yl, xh, yh);
		end

		// Drain, then give a stray result time to show up
		wait_drained();
		repeat (NUM_SLOTS + 8) @(posedge clk);

		$display("covered %0d loads and %0d queries over three pacing phases",
			n_loads, n_queries);
		$display("answers checked: %0d contained, %0d boundary, %0d outside",
			chk_contained, chk_boundary, chk_outside);
		if (chk_errors == 0 && chk_pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
